FILE: hdl/cwms_pkg.sv
package cwms_pkg;

   localparam int MEM_WORDS   = 100;
   localparam int BLOCK_WORDS = 10;
   localparam int ADDR_W      = $clog2(MEM_WORDS);
   localparam int CNT_W       = 7;
   localparam int BLK_W       = $clog2(BLOCK_WORDS + 1);

   localparam logic [31:0] SPACES = 32'h2020_2020;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_H    = 8'h48;
   localparam logic [7:0] CH_L    = 8'h4C;
   localparam logic [7:0] CH_S    = 8'h53;
   localparam logic [7:0] CH_C    = 8'h43;
   localparam logic [7:0] CH_B    = 8'h42;
   localparam logic [7:0] CH_G    = 8'h47;
   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_R    = 8'h52;
   localparam logic [7:0] CH_D    = 8'h44;
   localparam logic [7:0] CH_T    = 8'h54;

   typedef enum logic [1:0] {
      OP_JOB  = 2'd0,
      OP_LOAD = 2'd1,
      OP_STEP = 2'd2,
      OP_DATA = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK   = 3'd0,
      ST_WAIT = 3'd1,
      ST_OUT  = 3'd2,
      ST_HALT = 3'd3,
      ST_ADDR = 3'd4,
      ST_IGN  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_H,
      KIND_LR,
      KIND_SR,
      KIND_CR,
      KIND_BT,
      KIND_GD,
      KIND_PD
   } kind_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_LOAD,
      WR_DATA,
      WR_STORE
   } wr_sel_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_IC,
      RD_ADDR,
      RD_PTR
   } rd_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_FETCH,
      S_LR,
      S_CR,
      S_PD,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       latch_req;
      logic       clear_job;
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
      logic       ic_inc;
      logic       ic_load;
      logic       set_halt;
      logic       load_gr;
      logic       load_flag;
      logic       start_gd;
      logic       ptr_load;
      logic       ptr_inc;
      logic       emit;
      status_type emit_status;
      logic       emit_last;
      logic       emit_word;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       lp_full;
      logic       data_pending;
      logic       data_ok;
      logic       data_last;
      logic       halted;
      logic       ic_over;
      logic       flag;
      kind_type   kind;
      logic       addr_bad;
   } sts_type;

endpackage

FILE: hdl/cwms_ctrl.sv
module cwms_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cwms_pkg::sts_type sts,
   output cwms_pkg::cmd_type cmd
);

   cwms_pkg::state_type             state_ff, state_in;
   cwms_pkg::status_type            stat_ff, stat_in;
   logic [cwms_pkg::BLK_W-1:0]      cnt_ff, cnt_in;
   logic                            pd_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwms_pkg::S_IDLE;
         stat_ff  <= cwms_pkg::ST_OK;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign pd_last = (cnt_ff == cwms_pkg::BLK_W'(cwms_pkg::BLOCK_WORDS - 1));

   always_comb begin
      cmd             = '0;
      cmd.wr_sel      = cwms_pkg::WR_NONE;
      cmd.rd_sel      = cwms_pkg::RD_NONE;
      cmd.emit_status = cwms_pkg::ST_OK;
      state_in        = state_ff;
      stat_in         = stat_ff;
      cnt_in          = cnt_ff;
      busy            = 1'b1;
      unique case (state_ff)
         cwms_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = cwms_pkg::S_DISPATCH;
            end
         end
         cwms_pkg::S_DISPATCH: begin
            state_in = cwms_pkg::S_RESP;
            unique case (sts.op)
               cwms_pkg::OP_JOB: begin
                  cmd.clear_job = 1'b1;
                  stat_in       = cwms_pkg::ST_OK;
               end
               cwms_pkg::OP_LOAD: begin
                  if (!sts.lp_full) begin
                     cmd.wr_sel = cwms_pkg::WR_LOAD;
                     stat_in    = cwms_pkg::ST_OK;
                  end else begin
                     stat_in = cwms_pkg::ST_IGN;
                  end
               end
               cwms_pkg::OP_DATA: begin
                  if (sts.data_ok) begin
                     cmd.wr_sel = cwms_pkg::WR_DATA;
                     stat_in    = sts.data_last ? cwms_pkg::ST_OK : cwms_pkg::ST_WAIT;
                  end else begin
                     stat_in = cwms_pkg::ST_IGN;
                  end
               end
               cwms_pkg::OP_STEP: begin
                  if (sts.halted) begin
                     stat_in = cwms_pkg::ST_HALT;
                  end else if (sts.data_pending) begin
                     stat_in = cwms_pkg::ST_WAIT;
                  end else if (sts.ic_over) begin
                     cmd.set_halt = 1'b1;
                     stat_in      = cwms_pkg::ST_ADDR;
                  end else begin
                     cmd.rd_sel = cwms_pkg::RD_IC;
                     cmd.ic_inc = 1'b1;
                     state_in   = cwms_pkg::S_FETCH;
                  end
               end
               default: stat_in = cwms_pkg::ST_IGN;
            endcase
         end
         cwms_pkg::S_FETCH: begin
            // instruction word is on the read port now
            state_in = cwms_pkg::S_RESP;
            stat_in  = cwms_pkg::ST_OK;
            if (sts.kind == cwms_pkg::KIND_H) begin
               cmd.set_halt = 1'b1;
               stat_in      = cwms_pkg::ST_HALT;
            end else if (sts.kind == cwms_pkg::KIND_NONE) begin
               stat_in = cwms_pkg::ST_OK;
            end else if (sts.addr_bad) begin
               cmd.set_halt = 1'b1;
               stat_in      = cwms_pkg::ST_ADDR;
            end else begin
               unique case (sts.kind)
                  cwms_pkg::KIND_LR: begin
                     cmd.rd_sel = cwms_pkg::RD_ADDR;
                     state_in   = cwms_pkg::S_LR;
                  end
                  cwms_pkg::KIND_CR: begin
                     cmd.rd_sel = cwms_pkg::RD_ADDR;
                     state_in   = cwms_pkg::S_CR;
                  end
                  cwms_pkg::KIND_SR: cmd.wr_sel = cwms_pkg::WR_STORE;
                  cwms_pkg::KIND_BT: cmd.ic_load = sts.flag;
                  cwms_pkg::KIND_GD: begin
                     cmd.start_gd = 1'b1;
                     stat_in      = cwms_pkg::ST_WAIT;
                  end
                  cwms_pkg::KIND_PD: begin
                     cmd.rd_sel   = cwms_pkg::RD_ADDR;
                     cmd.ptr_load = 1'b1;
                     cnt_in       = '0;
                     state_in     = cwms_pkg::S_PD;
                  end
                  default: stat_in = cwms_pkg::ST_OK;
               endcase
            end
         end
         cwms_pkg::S_LR: begin
            cmd.load_gr = 1'b1;
            stat_in     = cwms_pkg::ST_OK;
            state_in    = cwms_pkg::S_RESP;
         end
         cwms_pkg::S_CR: begin
            cmd.load_flag = 1'b1;
            stat_in       = cwms_pkg::ST_OK;
            state_in      = cwms_pkg::S_RESP;
         end
         cwms_pkg::S_PD: begin
            // emit the word read last cycle, read the next one
            cmd.emit        = 1'b1;
            cmd.emit_status = cwms_pkg::ST_OUT;
            cmd.emit_word   = 1'b1;
            cmd.emit_last   = pd_last;
            if (pd_last) begin
               state_in = cwms_pkg::S_IDLE;
            end else begin
               cmd.rd_sel  = cwms_pkg::RD_PTR;
               cmd.ptr_inc = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end
         end
         cwms_pkg::S_RESP: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = stat_ff;
            cmd.emit_last   = 1'b1;
            state_in        = cwms_pkg::S_IDLE;
         end
         default: state_in = cwms_pkg::S_IDLE;
      endcase
   end

endmodule

FILE: hdl/cwms_dp.sv
module cwms_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_opcode,
   input  logic [31:0]       req_word_in,
   input  cwms_pkg::cmd_type cmd,
   output cwms_pkg::sts_type sts,
   output logic              rsp_strobe,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_word_out,
   output logic              rsp_last,
   output logic [6:0]        rsp_next_counter,
   output logic              rsp_flag_out
);

   localparam int AW = cwms_pkg::ADDR_W;
   localparam int CW = cwms_pkg::CNT_W;

   logic [31:0]                mem [cwms_pkg::MEM_WORDS];
   logic [cwms_pkg::MEM_WORDS-1:0] valid_ff;
   logic [31:0]                rd_data_ff;
   logic                       rd_valid_ff;
   logic [31:0]                rd_word;

   cwms_pkg::opcode_type       op_ff;
   logic [31:0]                win_ff;
   logic [CW-1:0]              ic_ff, lp_ff, da_ff, ptr_ff;
   logic [31:0]                gr_ff;
   logic                       flag_ff, halted_ff;
   logic [cwms_pkg::BLK_W-1:0] dr_ff;

   logic                       rsp_strobe_ff, rsp_last_ff, rsp_flag_ff;
   logic [2:0]                 rsp_status_ff;
   logic [31:0]                rsp_word_ff;
   logic [CW-1:0]              rsp_ic_ff;

   logic [7:0]                 c0, c1, c2, c3;
   logic                       dig_ok, is_block;
   logic [7:0]                 addr_val;
   logic [CW-1:0]              addr_cw;
   cwms_pkg::kind_type         kind;

   logic                       wr_en;
   logic [CW-1:0]              wr_addr;
   logic [31:0]                wr_data;
   logic                       rd_en;
   logic [CW-1:0]              rd_addr;

   assign rd_word = rd_valid_ff ? rd_data_ff : cwms_pkg::SPACES;

   // instruction decode from the word on the read port
   assign c0 = rd_word[31:24];
   assign c1 = rd_word[23:16];
   assign c2 = rd_word[15:8];
   assign c3 = rd_word[7:0];
   assign dig_ok = (c2 >= cwms_pkg::CH_ZERO) && (c2 <= cwms_pkg::CH_NINE) &&
                   (c3 >= cwms_pkg::CH_ZERO) && (c3 <= cwms_pkg::CH_NINE);
   assign addr_val = ({4'd0, c2[3:0]} * 8'd10) + {4'd0, c3[3:0]};
   assign addr_cw  = addr_val[CW-1:0];
   assign is_block = (c1 == cwms_pkg::CH_D);

   always_comb begin
      kind = cwms_pkg::KIND_NONE;
      if (c0 == cwms_pkg::CH_H) begin
         kind = cwms_pkg::KIND_H;
      end else if (c1 == cwms_pkg::CH_R) begin
         if (c0 == cwms_pkg::CH_L) kind = cwms_pkg::KIND_LR;
         else if (c0 == cwms_pkg::CH_S) kind = cwms_pkg::KIND_SR;
         else if (c0 == cwms_pkg::CH_C) kind = cwms_pkg::KIND_CR;
      end else if (c1 == cwms_pkg::CH_T) begin
         if (c0 == cwms_pkg::CH_B) kind = cwms_pkg::KIND_BT;
      end else if (c1 == cwms_pkg::CH_D) begin
         if (c0 == cwms_pkg::CH_G) kind = cwms_pkg::KIND_GD;
         else if (c0 == cwms_pkg::CH_P) kind = cwms_pkg::KIND_PD;
      end
   end

   always_comb begin
      sts.op           = op_ff;
      sts.lp_full      = (lp_ff >= CW'(cwms_pkg::MEM_WORDS));
      sts.data_pending = (dr_ff != '0);
      sts.data_ok      = (dr_ff != '0) && (da_ff < CW'(cwms_pkg::MEM_WORDS));
      sts.data_last    = (dr_ff == cwms_pkg::BLK_W'(1));
      sts.halted       = halted_ff;
      sts.ic_over      = (ic_ff >= CW'(cwms_pkg::MEM_WORDS));
      sts.flag         = flag_ff;
      sts.kind         = kind;
      sts.addr_bad     = !dig_ok || (addr_val >= 8'(cwms_pkg::MEM_WORDS)) ||
                         (is_block && ((addr_val + 8'(cwms_pkg::BLOCK_WORDS)) >
                                       8'(cwms_pkg::MEM_WORDS)));
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = lp_ff;
      wr_data = win_ff;
      case (cmd.wr_sel)
         cwms_pkg::WR_LOAD:  wr_addr = lp_ff;
         cwms_pkg::WR_DATA:  wr_addr = da_ff;
         cwms_pkg::WR_STORE: begin
            wr_addr = addr_cw;
            wr_data = gr_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = ic_ff;
      case (cmd.rd_sel)
         cwms_pkg::RD_IC:   rd_addr = ic_ff;
         cwms_pkg::RD_ADDR: rd_addr = addr_cw;
         cwms_pkg::RD_PTR:  rd_addr = ptr_ff;
         default:           rd_en   = 1'b0;
      endcase
   end

   // word store: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   // an entry that is not valid reads as four spaces
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_job) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr[AW-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr[AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff  <= cwms_pkg::opcode_type'(req_opcode);
         win_ff <= req_word_in;
      end
      if (cmd.ptr_load) begin
         ptr_ff <= addr_cw + 1'b1;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff     <= '0;
         lp_ff     <= '0;
         da_ff     <= '0;
         dr_ff     <= '0;
         halted_ff <= 1'b0;
         gr_ff     <= '0;
         flag_ff   <= 1'b0;
      end else if (cmd.clear_job) begin
         ic_ff     <= '0;
         lp_ff     <= '0;
         da_ff     <= '0;
         dr_ff     <= '0;
         halted_ff <= 1'b0;
      end else begin
         if (cmd.wr_sel == cwms_pkg::WR_LOAD) begin
            lp_ff <= lp_ff + 1'b1;
         end
         if (cmd.wr_sel == cwms_pkg::WR_DATA) begin
            da_ff <= da_ff + 1'b1;
            dr_ff <= dr_ff - 1'b1;
         end
         if (cmd.start_gd) begin
            da_ff <= addr_cw;
            dr_ff <= cwms_pkg::BLK_W'(cwms_pkg::BLOCK_WORDS);
         end
         if (cmd.ic_load) begin
            ic_ff <= addr_cw;
         end else if (cmd.ic_inc) begin
            ic_ff <= ic_ff + 1'b1;
         end
         if (cmd.set_halt) begin
            halted_ff <= 1'b1;
         end
         if (cmd.load_gr) begin
            gr_ff <= rd_word;
         end
         if (cmd.load_flag) begin
            flag_ff <= (gr_ff == rd_word);
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_word_ff   <= cmd.emit_word ? rd_word : '0;
         rsp_last_ff   <= cmd.emit_last;
         rsp_ic_ff     <= ic_ff;
         rsp_flag_ff   <= flag_ff;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_word_out     = rsp_word_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_next_counter = rsp_ic_ff;
   assign rsp_flag_out     = rsp_flag_ff;

endmodule

FILE: hdl/char_word_machine_step_unit.sv
// Character-word machine, one transaction at a time.
// Request channel: req_opcode and req_word_in are taken at a rising edge
// where start is high and busy is low; busy stays high until the last
// result of that transaction has been driven.
// Result channel: each result sits on the rsp_ ports for exactly one cycle,
// marked by rsp_strobe; rsp_last flags the final result of a transaction.
// The receiver cannot stall, so results go out as soon as they are ready.
// After accept, each transaction passes the dispatch state; start job, load
// and data words, and a step that stops before the fetch, go on to the response
// state. Other steps pass the fetch state first; LR and CR then pass an operand
// state, and a PD step strobes ten results on consecutive cycles, one word of
// the block each. Each result is registered onto the rsp_ ports. busy drops
// with the last strobe, so the next transaction can be accepted at the edge
// that takes that result. The pace is set by the word store's single registered
// read port: the fetch and the operand read each go through its read register.
// Reset (synchronous, active high) empties the store to spaces through a
// per-word valid bit and zeros the instruction, load and data counters, the
// register, the flag and the halt bit; no clearing pass is needed.
module char_word_machine_step_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_word_in,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_word_out,
   output logic        rsp_last,
   output logic [6:0]  rsp_next_counter,
   output logic        rsp_flag_out
);

   cwms_pkg::cmd_type cmd;
   cwms_pkg::sts_type sts;

   cwms_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   cwms_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_opcode       (req_opcode),
      .req_word_in      (req_word_in),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_word_out     (rsp_word_out),
      .rsp_last         (rsp_last),
      .rsp_next_counter (rsp_next_counter),
      .rsp_flag_out     (rsp_flag_out)
   );

endmodule
